### src/derivative_jacobian_mac_unit_macros.svh
// Assertion macros for the jacobian MAC unit.
// Used by the top level; expects clk and arst_n in scope.
`ifndef DERIVATIVE_JACOBIAN_MAC_UNIT_MACROS_SVH
`define DERIVATIVE_JACOBIAN_MAC_UNIT_MACROS_SVH

// same-cycle implication, quiet while in reset
`define DJM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet while in reset
`define DJM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/djm_pkg.sv
// Shared types, constants and helpers for the jacobian MAC unit.
// No dependencies.
package djm_pkg;

	localparam int unsigned MAX_NODES = 1024;
	localparam int unsigned CNT_W     = 11;
	localparam int unsigned ROWS      = 3;
	localparam int unsigned COLS      = 9;
	localparam int unsigned ACC_N     = ROWS * COLS;

	// configuration register indexes
	localparam logic [1:0] CFG_DIMS  = 2'd0;
	localparam logic [1:0] CFG_ORDER = 2'd1;
	localparam logic [1:0] CFG_COUNT = 2'd2;

	typedef struct packed {
		logic signed [31:0] comp_x;
		logic signed [31:0] comp_y;
		logic signed [31:0] comp_z;
		logic signed [31:0] deriv_0;
		logic signed [31:0] deriv_1;
		logic signed [31:0] deriv_2;
		logic signed [31:0] deriv_3;
		logic signed [31:0] deriv_4;
		logic signed [31:0] deriv_5;
		logic signed [31:0] deriv_6;
		logic signed [31:0] deriv_7;
		logic signed [31:0] deriv_8;
	} node_t;

	typedef struct packed {
		logic signed [63:0] entry_value;
		logic [1:0]         entry_row;
		logic [3:0]         entry_col;
		logic               entry_last;
	} entry_t;

	// request handed from front to back: node plus its classification
	typedef struct packed {
		node_t node;
		logic  dims3;
		logic  ord3;
		logic  last;
	} work_t;

	typedef enum logic [1:0] {
		BK_RUN,
		BK_DRAIN,
		BK_EMIT
	} bk_state_t;

	// highest active column for a shape
	function automatic logic [3:0] last_col(input logic dims3, input logic ord3);
		logic [3:0] res;
		case ({dims3, ord3})
			2'b00:   res = 4'd2;
			2'b01:   res = 4'd3;
			2'b10:   res = 4'd5;
			default: res = 4'd8;
		endcase
		return res;
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] s;
		s = a + b;
		if ((a[63] == b[63]) && (s[63] != a[63])) begin
			s = b[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end
		return s;
	endfunction

endpackage

### src/djm_front.sv
// Front end: config registers, request intake, node counting, two-entry queue.
// Depends on djm_pkg.
module djm_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  djm_pkg::node_t node,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [10:0]   cfg_data,
	output logic          q_valid,
	output djm_pkg::work_t q_item,
	input  logic          q_pop
);
	import djm_pkg::*;

	logic [1:0]       dims_q;
	logic [1:0]       order_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] seen_q;
	work_t            mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;

	logic             accept;
	logic             cfg_we;
	logic             dims3;
	logic             ord3;
	logic [CNT_W-1:0] eff_cnt;
	logic [CNT_W-1:0] seen_inc;
	logic             done;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	assign full    = (fill_q == 2'd2);
	assign accept  = push && !full;
	assign q_valid = (fill_q != 2'd0);
	assign q_item  = mem_q[rd_ptr_q];

	// odd codes fall back to 3D / second order
	assign dims3 = (dims_q != 2'd2);
	assign ord3  = (order_q == 2'd3);

	always_comb begin
		if (count_q == '0) begin
			eff_cnt = CNT_W'(1);
		end else if (count_q > CNT_W'(MAX_NODES)) begin
			eff_cnt = CNT_W'(MAX_NODES);
		end else begin
			eff_cnt = count_q;
		end
	end

	assign seen_inc = seen_q + CNT_W'(1);
	assign done     = (seen_inc >= eff_cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q  <= 2'd3;
			order_q <= 2'd2;
			count_q <= CNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIMS:  dims_q  <= cfg_data[1:0];
				CFG_ORDER: order_q <= cfg_data[1:0];
				CFG_COUNT: count_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (accept) begin
				seen_q   <= done ? '0 : seen_inc;
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + 2'(accept) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_q[wr_ptr_q] <= '{node: node, dims3: dims3, ord3: ord3, last: done};
		end
	end

endmodule

### src/djm_back.sv
// Back end: 27 MAC lanes (multiply stage, saturating accumulate) and the
// column-major emit sequencer. Depends on djm_pkg.
module djm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  djm_pkg::work_t q_item,
	output logic           q_pop,
	input  logic           out_full,
	output logic           out_push,
	output djm_pkg::entry_t out_entry
);
	import djm_pkg::*;

	bk_state_t          state_q;
	bk_state_t          state_d;
	logic signed [63:0] prod_s1 [ACC_N];
	logic               act_s1  [ACC_N];
	logic               valid_s1;
	logic signed [63:0] acc_q   [ACC_N];
	logic [1:0]         row_q;
	logic [3:0]         col_q;
	logic               em_dims3_q;
	logic               em_ord3_q;

	logic signed [31:0] comp_a  [ROWS];
	logic signed [31:0] deriv_a [COLS];
	logic [3:0]         in_last_col;
	logic [3:0]         em_last_col;
	logic [1:0]         em_last_row;
	logic [4:0]         emit_idx;
	logic               emit_last;
	logic               clear;

	assign comp_a[0]  = q_item.node.comp_x;
	assign comp_a[1]  = q_item.node.comp_y;
	assign comp_a[2]  = q_item.node.comp_z;
	assign deriv_a[0] = q_item.node.deriv_0;
	assign deriv_a[1] = q_item.node.deriv_1;
	assign deriv_a[2] = q_item.node.deriv_2;
	assign deriv_a[3] = q_item.node.deriv_3;
	assign deriv_a[4] = q_item.node.deriv_4;
	assign deriv_a[5] = q_item.node.deriv_5;
	assign deriv_a[6] = q_item.node.deriv_6;
	assign deriv_a[7] = q_item.node.deriv_7;
	assign deriv_a[8] = q_item.node.deriv_8;

	assign in_last_col = last_col(q_item.dims3, q_item.ord3);
	assign em_last_col = last_col(em_dims3_q, em_ord3_q);
	assign em_last_row = em_dims3_q ? 2'd2 : 2'd1;
	assign emit_idx    = 5'((6'(col_q) * 6'd3) + 6'(row_q));
	assign emit_last   = (col_q == em_last_col) && (row_q == em_last_row);
	assign clear       = out_push && emit_last;

	// one lane per (row, col); index col*3+row
	for (genvar c = 0; c < COLS; c++) begin : g_col
		for (genvar r = 0; r < ROWS; r++) begin : g_row
			localparam int unsigned K = c * ROWS + r;
			logic signed [63:0] prod;
			logic               act;

			assign prod = comp_a[r] * deriv_a[c];
			assign act  = ((r < 2) || q_item.dims3) && (4'(c) <= in_last_col);

			always_ff @(posedge clk) begin
				if (q_pop) begin
					prod_s1[K] <= prod;
					act_s1[K]  <= act;
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					acc_q[K] <= '0;
				end else if (clear) begin
					acc_q[K] <= '0;
				end else if (valid_s1 && act_s1[K]) begin
					acc_q[K] <= sat_add(acc_q[K], prod_s1[K]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_RUN;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= q_pop;
		end
	end

	// emit cursor and the shape of the element being emitted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= 2'd0;
			col_q      <= 4'd0;
			em_dims3_q <= 1'b1;
			em_ord3_q  <= 1'b0;
		end else begin
			if (q_pop && q_item.last) begin
				em_dims3_q <= q_item.dims3;
				em_ord3_q  <= q_item.ord3;
			end
			if (out_push) begin
				if (emit_last) begin
					row_q <= 2'd0;
					col_q <= 4'd0;
				end else if (row_q == em_last_row) begin
					row_q <= 2'd0;
					col_q <= col_q + 4'd1;
				end else begin
					row_q <= row_q + 2'd1;
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_RUN: begin
				if (q_pop && q_item.last) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: begin
				state_d = BK_EMIT;
			end
			BK_EMIT: begin
				if (clear) begin
					state_d = BK_RUN;
				end
			end
			default: state_d = BK_RUN;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		out_push = 1'b0;
		case (state_q)
			BK_RUN:   q_pop    = q_valid;
			BK_EMIT:  out_push = !out_full;
			default:  ;
		endcase
	end

	assign out_entry = '{entry_value: acc_q[emit_idx], entry_row: row_q,
		entry_col: col_q, entry_last: emit_last};

endmodule

### src/djm_outq.sv
// Two-entry result queue between the emit sequencer and the result port.
// Depends on djm_pkg.
module djm_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	output logic            wr_full,
	input  djm_pkg::entry_t din,
	output logic            empty,
	input  logic            pop,
	output djm_pkg::entry_t dout
);
	import djm_pkg::*;

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_wr;
	logic       do_rd;

	assign wr_full = (fill_q == 2'd2);
	assign empty   = (fill_q == 2'd0);
	assign do_wr   = wr && !wr_full;
	assign do_rd   = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + 2'(do_wr) - 2'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

### src/derivative_jacobian_mac_unit.sv
// Jacobian MAC unit top level. Depends on djm_pkg, djm_front, djm_back, djm_outq.
// Throughput: one node per cycle while an element accumulates (27 parallel MAC lanes).
// A closing node adds a drain state plus the emit of rows*cols entries (6 to 27, one entry per
// cycle while the result queue has room), during which no further node enters the MAC lanes.
// After the last node: multiply register, accumulate (drain), then emit into the result queue.
// Reset (arst_n low, async): 3D / second order / one node, accumulators, counts, queues clear.
`include "derivative_jacobian_mac_unit_macros.svh"

module derivative_jacobian_mac_unit (
	input  logic            clk,
	input  logic            arst_n,
	// node request side
	input  logic            push,
	output logic            full,
	input  djm_pkg::node_t  node,
	// configuration writes
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [10:0]     cfg_data,
	// result side
	output logic            empty,
	input  logic            pop,
	output djm_pkg::entry_t entry
);
	import djm_pkg::*;

	// front -> back work queue
	logic   q_valid;
	work_t  q_item;
	logic   q_pop;

	// back -> result queue
	logic   out_push;
	logic   out_full;
	entry_t out_entry;

	// Front: holds config, counts nodes and tags the one that closes an
	// element, so the back never has to look at the config registers.
	djm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.node      (node),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	// Back: multiply stage, then saturating accumulate; on a tagged node it
	// drains the pipe and walks the active entries column by column.
	djm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_entry (out_entry)
	);

	// Result queue decouples emission from the consumer's pop pattern.
	djm_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (out_push),
		.wr_full (out_full),
		.din     (out_entry),
		.empty   (empty),
		.pop     (pop),
		.dout    (entry)
	);

	// back only takes work that is there, and only emits into free room
	`DJM_ASSERT_NOW(a_pop_has_data, q_pop, q_valid, "back popped an empty work queue")
	`DJM_ASSERT_NOW(a_push_has_room, out_push, !out_full, "emit into a full result queue")
	// a closing node never enters the lanes back to back with emission start
	`DJM_ASSERT_NEXT(a_last_drains, q_pop && q_item.last, !q_pop, "pop right after closing node")
	// the last entry of an element always sits on row 1 or row 2
	`DJM_ASSERT_NOW(a_last_row, !empty && entry.entry_last,
		entry.entry_row == 2'd1 || entry.entry_row == 2'd2, "last entry on bad row")

endmodule

### tb/derivative_jacobian_mac_unit_tb.sv
// Self-checking testbench for the jacobian MAC unit (derivative_jacobian_mac_unit).
// Depends on djm_pkg for the node, entry and register index definitions.
// Holds its own contraction model; compares every popped entry against it.
`timescale 1ns / 1ps

module derivative_jacobian_mac_unit_tb;
	import djm_pkg::*;

	localparam int          SETTLE_CYCLES = 40;        // drain and emit of one element plus in-flight work, padded
	localparam int          HOLD_CYCLES   = 400;       // long receiver hold-off
	localparam int          RANDOM_NODES  = 330;
	localparam longint      LIMIT_NS      = 8_000_000; // simulation time limit in ns
	localparam logic [1:0]  CFG_SPARE     = 2'd3;      // index with no register behind it

	// ------------------------------------------------------------------
	// Scoreboard: mirrors the 27 accumulators and queues expected entries
	// ------------------------------------------------------------------
	class jacobian_scoreboard;
		logic [1:0]         dims_reg;
		logic [1:0]         order_reg;
		logic [10:0]        count_reg;
		logic signed [63:0] jac_acc [ACC_N];
		logic [10:0]        nodes_in_element;
		entry_t             expected_entries [$];
		int                 errors;
		int                 nodes_taken;
		int                 elements_done;
		int                 entries_checked;

		function new();
			dims_reg         = 2'd3;
			order_reg        = 2'd2;
			count_reg        = 11'd1;
			nodes_in_element = '0;
			foreach (jac_acc[k]) jac_acc[k] = '0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [10:0] val);
			case (idx)
				CFG_DIMS:  dims_reg  = val[1:0];
				CFG_ORDER: order_reg = val[1:0];
				CFG_COUNT: count_reg = val;
				default: ;
			endcase
		endfunction

		function int row_count();
			return (dims_reg == 2'd2) ? 2 : 3;
		endfunction

		function int col_count();
			int rows;
			rows = row_count();
			return (order_reg == 2'd3) ? rows * rows : rows * (rows + 1) / 2;
		endfunction

		// nodes per element after clamping
		function int target_count();
			if (count_reg == 0) return 1;
			if (count_reg > MAX_NODES) return MAX_NODES;
			return count_reg;
		endfunction

		function logic signed [63:0] clamp_add(logic signed [63:0] a, logic signed [63:0] b);
			logic signed [64:0] wa;
			logic signed [64:0] wb;
			logic signed [64:0] s;
			wa = a;
			wb = b;
			s  = wa + wb;
			if (s[64] != s[63])
				return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
			return s[63:0];
		endfunction

		function void note_node(node_t n);
			logic signed [31:0] comp [3];
			logic signed [31:0] der [9];
			logic signed [63:0] cw;
			logic signed [63:0] dw;
			entry_t             e;
			int                 rows;
			int                 cols;
			rows = row_count();
			cols = col_count();
			comp = '{n.comp_x, n.comp_y, n.comp_z};
			der  = '{n.deriv_0, n.deriv_1, n.deriv_2, n.deriv_3, n.deriv_4,
				n.deriv_5, n.deriv_6, n.deriv_7, n.deriv_8};
			for (int c = 0; c < cols; c++) begin
				for (int r = 0; r < rows; r++) begin
					cw = comp[r];
					dw = der[c];
					jac_acc[c * 3 + r] = clamp_add(jac_acc[c * 3 + r], cw * dw);
				end
			end
			nodes_taken++;
			nodes_in_element = nodes_in_element + 11'd1;
			if (nodes_in_element < target_count())
				return;
			// element complete: column-major dump, then clear everything
			for (int c = 0; c < cols; c++) begin
				for (int r = 0; r < rows; r++) begin
					e.entry_value = jac_acc[c * 3 + r];
					e.entry_row   = r[1:0];
					e.entry_col   = c[3:0];
					e.entry_last  = (c == cols - 1) && (r == rows - 1);
					expected_entries.push_back(e);
				end
			end
			foreach (jac_acc[k]) jac_acc[k] = '0;
			nodes_in_element = '0;
			elements_done++;
		endfunction

		function void check_entry(entry_t got);
			entry_t want;
			if (expected_entries.size() == 0) begin
				$error("unexpected entry: value %0d row %0d col %0d last %0d",
					got.entry_value, got.entry_row, got.entry_col, got.entry_last);
				errors++;
				return;
			end
			want = expected_entries.pop_front();
			entries_checked++;
			if (got.entry_value !== want.entry_value) begin
				$error("entry_value: expected %0d, got %0d", want.entry_value, got.entry_value);
				errors++;
			end
			if (got.entry_row !== want.entry_row) begin
				$error("entry_row: expected %0d, got %0d", want.entry_row, got.entry_row);
				errors++;
			end
			if (got.entry_col !== want.entry_col) begin
				$error("entry_col: expected %0d, got %0d", want.entry_col, got.entry_col);
				errors++;
			end
			if (got.entry_last !== want.entry_last) begin
				$error("entry_last: expected %0d, got %0d", want.entry_last, got.entry_last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_entries.size();
		endfunction
	endclass

	// ------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	node_t       node;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [10:0] cfg_data;
	logic        empty;
	logic        pop;
	entry_t      entry;

	derivative_jacobian_mac_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.node      (node),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.empty     (empty),
		.pop       (pop),
		.entry     (entry)
	);

	jacobian_scoreboard sb = new();

	int burst_left;     // requests left in the current sender burst
	bit hold_request;   // main asks the receiver for a long hold-off
	int random_sent;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// hard stop in case something hangs
	initial begin
		#(LIMIT_NS);
		$display("Some tests failed");
		$finish;
	end

	// Result monitor: a request completes at an edge with pop high and empty low.
	// Values sampled here are the pre-edge ones, so no race with the DUT's flops.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_entry(entry);
	end

	// ------------------------------------------------------------------
	// Receiver: stalls in segments of random style; a hold-off request from
	// the main thread overrides everything while the hold-off lasts.
	// ------------------------------------------------------------------
	initial begin
		int hold_left;
		int seg_left;
		int seg_mode;
		int phase;
		hold_left = 0;
		seg_left  = 0;
		seg_mode  = 0;
		phase     = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (seg_left == 0) begin
				seg_mode = $urandom_range(0, 3);
				seg_left = $urandom_range(10, 200);
			end
			seg_left--;
			phase++;
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (seg_mode)
					0:       pop <= 1'b1;                          // no stalls at all
					1:       pop <= $urandom_range(0, 1);          // coin flip
					2:       pop <= ($urandom_range(0, 7) == 0);   // mostly stalled
					default: pop <= (phase % 5 != 0);              // fixed rhythm
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Offer one node request; returns in the step where it was accepted.
	// Between bursts push is dropped low for a random gap.
	task automatic send_node(input node_t n);
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 20);
		end
		push <= 1'b1;
		node <= n;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_node(n);
		burst_left--;
	endtask

	task automatic sender_idle();
		push       <= 1'b0;
		burst_left = 0;
	endtask

	// Wait until every expected entry has been popped, then let the block
	// finish any accumulation still in flight before touching registers.
	task automatic settle();
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the registers selected by mask back to back; mask[3] adds a write
	// to the unmapped index. Upper data bits of the 2-bit fields are junk.
	task automatic configure(input logic [1:0] dims, input logic [1:0] order,
			input logic [10:0] count, input logic [3:0] mask);
		logic [1:0]  idx_list [4];
		logic [10:0] vals [4];
		idx_list = '{CFG_DIMS, CFG_ORDER, CFG_COUNT, CFG_SPARE};
		vals[0]  = {9'($urandom), dims};
		vals[1]  = {9'($urandom), order};
		vals[2]  = count;
		vals[3]  = 11'($urandom);
		for (int i = 0; i < 4; i++) begin
			if (mask[i]) begin
				cfg_valid <= 1'b1;
				cfg_index <= idx_list[i];
				cfg_data  <= vals[i];
				@(posedge clk);
				while (!cfg_ready) @(posedge clk);
				sb.write_reg(idx_list[i], vals[i]);
			end
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0;
			3:       return 32'($urandom_range(0, 32'h3ffff)) - 32'h2_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic node_t random_node();
		node_t n;
		for (int i = 0; i < 12; i++)
			n[i * 32 +: 32] = pick_word();
		return n;
	endfunction

	function automatic node_t uniform_node(input logic [31:0] comp, input logic [31:0] der);
		node_t n;
		for (int i = 0; i < 12; i++)
			n[i * 32 +: 32] = (i >= 9) ? comp : der;   // comps sit in the top words
		return n;
	endfunction

	task automatic send_batch(input int count);
		repeat (count) send_node(random_node());
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int nodes;
		int target;
		int r;
		logic [10:0] count;
		arst_n       = 1'b0;
		push         = 1'b0;
		node         = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_DIMS;
		cfg_data     = '0;
		pop          = 1'b0;
		hold_request = 1'b0;
		burst_left   = 0;
		random_sent  = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// reset shape (3D, second order, one node): extreme opposite signs
		send_node(uniform_node(32'h7fff_ffff, 32'h8000_0000));
		sender_idle();
		settle();

		// positive saturation: two nodes of min*min in 2D; z and high cols ignored
		configure(2'd2, 2'd2, 11'd2, 4'b0111);
		repeat (2) send_node(uniform_node(32'h8000_0000, 32'h8000_0000));
		sender_idle();
		settle();

		// negative saturation on the third node, 2D third order
		configure(2'd2, 2'd3, 11'd3, 4'b0111);
		repeat (3) send_node(uniform_node(32'h8000_0000, 32'h7fff_ffff));
		sender_idle();
		settle();

		// full 27-entry shape with an all-zero node and a random node
		configure(2'd3, 2'd3, 11'd1, 4'b0111);
		send_node(uniform_node(32'h0, 32'h0));
		send_node(random_node());
		sender_idle();
		settle();

		// odd codes: dims 0 and order 1 fall back to 3D/second order, count 0 to one;
		// also a write to the unmapped index
		configure(2'd0, 2'd1, 11'd0, 4'b1111);
		send_node(random_node());
		sender_idle();
		settle();
		configure(2'd1, 2'd0, 11'd1, 4'b0111);
		send_node(random_node());
		sender_idle();
		settle();

		// count lowered mid-element below nodes already taken: next node closes it
		configure(2'd3, 2'd2, 11'd5, 4'b0111);
		send_batch(3);
		sender_idle();
		settle();
		configure(2'd3, 2'd2, 11'd2, 4'b0100);
		send_node(random_node());
		sender_idle();
		settle();

		// dims dropped mid-element: dump uses the 2D shape
		configure(2'd3, 2'd3, 11'd4, 4'b0111);
		send_batch(2);
		sender_idle();
		settle();
		configure(2'd2, 2'd3, 11'd4, 4'b0001);
		send_batch(2);
		sender_idle();
		settle();

		// --- back-pressure: receiver holds off while 27-entry elements pile up ---
		configure(2'd3, 2'd3, 11'd1, 4'b0111);
		hold_request = 1'b1;
		send_batch(12);
		random_sent += 12;
		sender_idle();
		settle();

		// --- oversized count: a few nodes, then the count is lowered to close it ---
		configure(2'($urandom_range(2, 3)), 2'($urandom_range(2, 3)),
			11'($urandom_range(MAX_NODES + 1, 2047)), 4'b0111);
		send_batch(3);
		sender_idle();
		settle();
		configure(2'd3, 2'd2, 11'd2, 4'b0100);
		send_node(random_node());
		sender_idle();
		settle();

		// --- random elements, sometimes left partial across a reconfiguration ---
		while (random_sent < RANDOM_NODES) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				count = 11'd0;
			else if (r < 14)
				count = 11'($urandom_range(1, 6));
			else
				count = 11'($urandom_range(7, 24));
			configure(($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 1))
					: 2'($urandom_range(2, 3)),
				($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 1))
					: 2'($urandom_range(2, 3)),
				count, 4'($urandom_range(1, 15)));
			target = sb.target_count();
			nodes  = target * $urandom_range(1, 3);
			if ($urandom_range(0, 4) == 0)
				nodes += $urandom_range(1, target);
			send_batch(nodes);
			random_sent += nodes;
			sender_idle();
			settle();
		end

		// settle() already waited out the pipeline
		if (sb.pending() != 0) begin
			$error("%0d entries never arrived", sb.pending());
			sb.errors++;
		end
		$display("Run covered %0d nodes in %0d elements, %0d entries compared.",
			sb.nodes_taken, sb.elements_done, sb.entries_checked);
		$display("Shapes 2D/3D, both orders, odd codes, saturation, oversized counts, back-pressure.");
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

### derivative_jacobian_mac_unit.f
+incdir+src
src/djm_pkg.sv
src/djm_front.sv
src/djm_back.sv
src/djm_outq.sv
src/derivative_jacobian_mac_unit.sv
tb/derivative_jacobian_mac_unit_tb.sv
